@@ sv/cbcs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbcs_pkg
// Shared types and constants of the cubic Bezier curve sampler.
// ----------------------------------------------------------------------------
package cbcs_pkg;

  localparam int SEG_W = 6;
  localparam logic [SEG_W-1:0] SEG_RESET = 6'd16;

  // Control that travels with each sample through the pipeline
  typedef struct packed {
    logic             valid;
    logic [SEG_W-1:0] index;
    logic             last;
  } cbcs_ctl_t;

endpackage

@@ sv/cbcs_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbcs_div
// Bit-serial restoring divider: 2^FRAC_BITS / segments, quotient and remainder.
// ----------------------------------------------------------------------------
module cbcs_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  logic [cbcs_pkg::SEG_W-1:0]   divisor_i,
  output logic                         busy_o,
  output logic [FRAC_BITS:0]           quot_o,
  output logic [cbcs_pkg::SEG_W-1:0]   rem_o
);
  import cbcs_pkg::*;

  localparam int CW = $clog2(FRAC_BITS + 1);

  logic              active_q;
  logic [CW-1:0]     cnt_q;
  logic [SEG_W-1:0]  rem_q, rem_d;
  logic [FRAC_BITS:0] quot_q;
  logic [SEG_W:0]    shifted;
  logic              ge;

  // Dividend is a single one at bit FRAC_BITS
  always_comb begin
    shifted = {rem_q, (cnt_q == CW'(FRAC_BITS))};
    ge      = shifted >= {1'b0, divisor_i};
    rem_d   = ge ? SEG_W'(shifted - {1'b0, divisor_i}) : shifted[SEG_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b1;
      cnt_q    <= CW'(FRAC_BITS);
      rem_q    <= '0;
    end else if (load_i) begin
      active_q <= 1'b1;
      cnt_q    <= CW'(FRAC_BITS);
      rem_q    <= '0;
    end else if (active_q) begin
      rem_q <= rem_d;
      if (cnt_q == '0) begin
        active_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (active_q && !load_i) begin
      quot_q <= {quot_q[FRAC_BITS-1:0], ge};
    end
  end

  assign busy_o = active_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

@@ sv/cbcs_weights.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbcs_weights
// Steps t one sample per cycle and pipelines the four Bernstein weights.
// ----------------------------------------------------------------------------
module cbcs_weights #(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [cbcs_pkg::SEG_W-1:0]   segs_i,
  input  logic [FRAC_BITS:0]           quot_i,
  input  logic [cbcs_pkg::SEG_W-1:0]   rem_i,
  output logic [FRAC_BITS+1:0]         w_o [4],
  output cbcs_pkg::cbcs_ctl_t          ctl_o,
  output logic                         busy_o
);
  import cbcs_pkg::*;

  localparam int TW = FRAC_BITS + 1;
  localparam int MW = 2 * FRAC_BITS + 2;
  localparam int WW = FRAC_BITS + 2;
  localparam logic [TW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [MW-1:0] HALF = {{(FRAC_BITS+3){1'b0}}, {(FRAC_BITS-1){1'b0}}} |
                                   (MW'(1) << (FRAC_BITS - 1));

  function automatic logic [TW-1:0] rnd_q(input logic [MW-1:0] a);
    logic [MW-1:0] s;
    s = a + HALF;
    return s[2*FRAC_BITS:FRAC_BITS];
  endfunction

  // step state
  logic             run_q;
  logic [SEG_W-1:0] idx_q;
  logic [TW-1:0]    t_q;
  logic [SEG_W-1:0] r_q;
  logic [SEG_W:0]   r_sum;
  logic             carry;

  // pipeline
  cbcs_ctl_t     ctl0_q, ctl1_q, ctl2_q, ctl3_q;
  logic [TW-1:0] t0_q, u0_q, t1_q, u1_q;
  logic [MW-1:0] uu_q, tt_q;
  logic [MW-1:0] a_q, b_q, c_q, d_q;
  logic [TW-1:0] u2, t2;
  logic [WW-1:0] w_q [4];
  logic [WW-1:0] rb, rc;

  always_comb begin
    r_sum = {1'b0, r_q} + {1'b0, rem_i};
    carry = r_sum >= {1'b0, segs_i};
    u2    = rnd_q(uu_q);
    t2    = rnd_q(tt_q);
    rb    = {1'b0, rnd_q(b_q)};
    rc    = {1'b0, rnd_q(c_q)};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      idx_q  <= '0;
      r_q    <= '0;
      t_q    <= '0;
      ctl0_q <= '0;
      ctl1_q <= '0;
      ctl2_q <= '0;
      ctl3_q <= '0;
    end else begin
      ctl0_q.valid <= run_q;
      ctl0_q.index <= idx_q;
      ctl0_q.last  <= (idx_q == segs_i);
      ctl1_q <= ctl0_q;
      ctl2_q <= ctl1_q;
      ctl3_q <= ctl2_q;
      if (start_i) begin
        run_q <= 1'b1;
        idx_q <= '0;
        r_q   <= '0;
        t_q   <= '0;
      end else if (run_q) begin
        if (idx_q == segs_i) begin
          run_q <= 1'b0;
        end else begin
          idx_q <= idx_q + SEG_W'(1);
          t_q   <= t_q + quot_i + TW'(carry);
          r_q   <= carry ? SEG_W'(r_sum - {1'b0, segs_i}) : r_sum[SEG_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    t0_q <= t_q;
    u0_q <= ONE - t_q;
    t1_q <= t0_q;
    u1_q <= u0_q;
    uu_q <= u0_q * u0_q;
    tt_q <= t0_q * t0_q;
    a_q  <= u2 * u1_q;
    b_q  <= u2 * t1_q;
    c_q  <= u1_q * t2;
    d_q  <= t2 * t1_q;
    w_q[0] <= {1'b0, rnd_q(a_q)};
    w_q[1] <= (rb << 1) + rb;
    w_q[2] <= (rc << 1) + rc;
    w_q[3] <= {1'b0, rnd_q(d_q)};
  end

  assign w_o    = w_q;
  assign ctl_o  = ctl3_q;
  assign busy_o = run_q | ctl0_q.valid | ctl1_q.valid | ctl2_q.valid | ctl3_q.valid;

`ifndef SYNTHESIS
  a_first_t_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl0_q.valid && ctl0_q.index == '0) |-> (t0_q == '0))
    else $error("first sample of a curve does not start at t = 0");

  a_last_t_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl0_q.valid && ctl0_q.last) |-> (t0_q == ONE))
    else $error("last sample of a curve does not land on t = 1");

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_o)
    else $error("new curve started while samples still in flight");
`endif

endmodule

@@ sv/cbcs_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbcs_lane
// One coordinate lane: holds four control coordinates, weights and sums them.
// ----------------------------------------------------------------------------
module cbcs_lane #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       load_i,
  input  logic signed [COORD_BITS-1:0]               p_i [4],
  input  logic        [FRAC_BITS+1:0]                w_i [4],
  output logic signed [COORD_BITS+FRAC_BITS+4:0]     sum_o
);
  localparam int PW = FRAC_BITS + 3 + COORD_BITS;
  localparam int SW = PW + 2;

  logic signed [COORD_BITS-1:0] p_q [4];
  logic signed [PW-1:0]         prod_q [4];
  logic signed [SW-1:0]         sum_q;

  // hold the control points of the current curve
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) begin
        p_q[k] <= '0;
      end
    end else if (load_i) begin
      p_q <= p_i;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      prod_q[k] <= $signed({1'b0, w_i[k]}) * p_q[k];
    end
    sum_q <= {{2{prod_q[0][PW-1]}}, prod_q[0]} + {{2{prod_q[1][PW-1]}}, prod_q[1]} +
             {{2{prod_q[2][PW-1]}}, prod_q[2]} + {{2{prod_q[3][PW-1]}}, prod_q[3]};
  end

  assign sum_o = sum_q;

endmodule

@@ sv/cbcs_merge.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbcs_merge
// Rounds and saturates the three lane sums and registers one sample point.
// ----------------------------------------------------------------------------
module cbcs_merge #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  cbcs_pkg::cbcs_ctl_t                    ctl_i,
  input  logic signed [COORD_BITS+FRAC_BITS+4:0] sum_x_i,
  input  logic signed [COORD_BITS+FRAC_BITS+4:0] sum_y_i,
  input  logic signed [COORD_BITS+FRAC_BITS+4:0] sum_z_i,
  output logic                                   valid_o,
  output logic signed [COORD_BITS-1:0]           x_o,
  output logic signed [COORD_BITS-1:0]           y_o,
  output logic signed [COORD_BITS-1:0]           z_o,
  output logic [cbcs_pkg::SEG_W-1:0]             index_o,
  output logic                                   last_o
);
  import cbcs_pkg::*;

  localparam int SW = COORD_BITS + FRAC_BITS + 5;
  localparam int RW = SW - FRAC_BITS;
  localparam logic signed [SW-1:0] HALF_S =
    {{(SW-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
  localparam logic signed [RW-1:0] MAX_R = {{(RW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [RW-1:0] MIN_R = {{(RW-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};

  // ties round toward +infinity, then clamp to the coordinate range
  function automatic logic [COORD_BITS-1:0] round_sat(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] biased;
    logic signed [SW-1:0] shifted;
    logic signed [RW-1:0] r;
    biased  = s + HALF_S;
    shifted = biased >>> FRAC_BITS;
    r       = shifted[RW-1:0];
    if (r > MAX_R) begin
      return MAX_R[COORD_BITS-1:0];
    end else if (r < MIN_R) begin
      return MIN_R[COORD_BITS-1:0];
    end
    return r[COORD_BITS-1:0];
  endfunction

  cbcs_ctl_t ctl4_q, ctl5_q;
  logic      valid_q;
  logic      last_q;
  logic [SEG_W-1:0] index_q;
  logic signed [COORD_BITS-1:0] x_q, y_q, z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl4_q  <= '0;
      ctl5_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      ctl4_q  <= ctl_i;
      ctl5_q  <= ctl4_q;
      valid_q <= ctl5_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= round_sat(sum_x_i);
    y_q     <= round_sat(sum_y_i);
    z_q     <= round_sat(sum_z_i);
    index_q <= ctl5_q.index;
    last_q  <= ctl5_q.last;
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign index_o = index_q;
  assign last_o  = last_q;

`ifndef SYNTHESIS
  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && last_q) |=> !valid_q)
    else $error("sample of a new curve directly follows the last sample");
`endif

endmodule

@@ sv/cubic_bezier_curve_sampler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_bezier_curve_sampler
// Samples a 3D cubic Bezier curve at segments+1 uniform steps of t.
// ----------------------------------------------------------------------------
//
//  channel   signals                          direction  handshake
//  -------   -------------------------------  ---------  ------------------------
//  request   start, p0..p3 x/y/z              in         start && !busy
//  config    cfg_valid_i, cfg_ready_o, data   in         cfg_valid_i && cfg_ready_o
//  sample    sample_valid_o, x/y/z/index/last out        one-cycle strobe
//
//  A request issues one sample per cycle, so it holds busy while the t
//  stepper issues segments+1 samples and the weight pipeline drains past
//  the lanes' control point registers. After the request is taken, the
//  first sample passes the weight pipeline, the lanes' product and sum
//  registers and the merge register. After reset and after every segments
//  write the serial divider finds 2^FRAC_BITS/segments, with busy high.
//  The receiver cannot stall: each sample is shown for exactly one cycle.
//
// ----------------------------------------------------------------------------
module cubic_bezier_curve_sampler #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_BITS-1:0]  p0_x_i,
  input  logic signed [COORD_BITS-1:0]  p0_y_i,
  input  logic signed [COORD_BITS-1:0]  p0_z_i,
  input  logic signed [COORD_BITS-1:0]  p1_x_i,
  input  logic signed [COORD_BITS-1:0]  p1_y_i,
  input  logic signed [COORD_BITS-1:0]  p1_z_i,
  input  logic signed [COORD_BITS-1:0]  p2_x_i,
  input  logic signed [COORD_BITS-1:0]  p2_y_i,
  input  logic signed [COORD_BITS-1:0]  p2_z_i,
  input  logic signed [COORD_BITS-1:0]  p3_x_i,
  input  logic signed [COORD_BITS-1:0]  p3_y_i,
  input  logic signed [COORD_BITS-1:0]  p3_z_i,
  // segments register
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cbcs_pkg::SEG_W-1:0]    cfg_data_i,
  // samples
  output logic                          sample_valid_o,
  output logic signed [COORD_BITS-1:0]  sample_x_o,
  output logic signed [COORD_BITS-1:0]  sample_y_o,
  output logic signed [COORD_BITS-1:0]  sample_z_o,
  output logic [cbcs_pkg::SEG_W-1:0]    sample_index_o,
  output logic                          last_sample_o
);
  import cbcs_pkg::*;

  localparam int SW = COORD_BITS + FRAC_BITS + 5;

  logic [SEG_W-1:0] segments_q;
  logic [SEG_W-1:0] segs_eff;
  logic             accept;
  logic             cfg_write;
  logic             div_busy;
  logic             gen_busy;
  logic [FRAC_BITS:0] quot;
  logic [SEG_W-1:0] rem;
  logic [FRAC_BITS+1:0] w [4];
  cbcs_ctl_t        ctl;
  logic signed [COORD_BITS-1:0] px [4];
  logic signed [COORD_BITS-1:0] py [4];
  logic signed [COORD_BITS-1:0] pz [4];
  logic signed [SW-1:0] sum_x, sum_y, sum_z;

  // take a request only when the divider is settled and the lanes are free;
  // hold off a segments write while a request is offered so both never land
  // on the same edge
  assign busy        = div_busy | gen_busy;
  assign accept      = start & ~busy;
  assign cfg_ready_o = ~busy & ~start;
  assign cfg_write   = cfg_valid_i & cfg_ready_o;

  // a zero segment count behaves as one segment
  assign segs_eff = (segments_q == '0) ? SEG_W'(1) : segments_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      segments_q <= SEG_RESET;
    end else if (cfg_write) begin
      segments_q <= cfg_data_i;
    end
  end

  // control points, gathered per coordinate lane
  assign px[0] = p0_x_i;
  assign px[1] = p1_x_i;
  assign px[2] = p2_x_i;
  assign px[3] = p3_x_i;
  assign py[0] = p0_y_i;
  assign py[1] = p1_y_i;
  assign py[2] = p2_y_i;
  assign py[3] = p3_y_i;
  assign pz[0] = p0_z_i;
  assign pz[1] = p1_z_i;
  assign pz[2] = p2_z_i;
  assign pz[3] = p3_z_i;

  // step size of t: quotient and remainder of 2^FRAC_BITS / segments
  cbcs_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (cfg_write),
    .divisor_i (segs_eff),
    .busy_o    (div_busy),
    .quot_o    (quot),
    .rem_o     (rem)
  );

  // t stepper and Bernstein weight pipeline, shared by all lanes
  cbcs_weights #(
    .FRAC_BITS (FRAC_BITS)
  ) u_weights (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .segs_i  (segs_eff),
    .quot_i  (quot),
    .rem_i   (rem),
    .w_o     (w),
    .ctl_o   (ctl),
    .busy_o  (gen_busy)
  );

  cbcs_lane #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_lane_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (accept),
    .p_i    (px),
    .w_i    (w),
    .sum_o  (sum_x)
  );

  cbcs_lane #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_lane_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (accept),
    .p_i    (py),
    .w_i    (w),
    .sum_o  (sum_y)
  );

  cbcs_lane #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_lane_z (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (accept),
    .p_i    (pz),
    .w_i    (w),
    .sum_o  (sum_z)
  );

  // round, clamp and present the point with its index
  cbcs_merge #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .sum_x_i (sum_x),
    .sum_y_i (sum_y),
    .sum_z_i (sum_z),
    .valid_o (sample_valid_o),
    .x_o     (sample_x_o),
    .y_o     (sample_y_o),
    .z_o     (sample_z_o),
    .index_o (sample_index_o),
    .last_o  (last_sample_o)
  );

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("busy did not rise after a request was taken");

  a_cfg_restarts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_write |=> div_busy)
    else $error("segments write did not restart the step divider");
`endif

endmodule
